// ===== hw/rtl/fbfl_pkg.sv =====
// Shared types and constants of the fixed block free list allocator.
// No dependencies; used by every module of the block.
`default_nettype none

package fbfl_pkg;

  localparam int BLOCK_COUNT = 64;
  localparam int IDX_W      = 6;
  localparam int LINK_W     = IDX_W + 1;
  localparam int SIZE_W     = 17;
  localparam int ALIGN_W    = 13;
  localparam int ADDR_W     = 32;
  localparam int COUNT_W    = 7;
  localparam int BYTES_W    = 23;
  localparam int STRIDE_W   = SIZE_W + 1;
  localparam int PROD_W     = IDX_W + STRIDE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(BLOCK_COUNT);

  localparam logic [SIZE_W-1:0]  BLOCK_BYTES_RST = SIZE_W'(64);
  localparam logic [ALIGN_W-1:0] ALIGN_BYTES_RST = ALIGN_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_BYTES = 2'd0,
    CFG_ALIGN_BYTES = 2'd1,
    CFG_POOL_BASE   = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SIZE  = 3'd1,
    ST_ALIGN = 3'd2,
    ST_EMPTY = 3'd3,
    ST_NONE  = 3'd4
  } status_t;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [SIZE_W-1:0]  request_size;
    logic [ALIGN_W-1:0] request_align;
    logic [IDX_W-1:0]   block_index;
    logic               is_null;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [IDX_W-1:0]   granted_index;
    logic [ADDR_W-1:0]  granted_address;
    logic [COUNT_W-1:0] live_blocks;
    logic [BYTES_W-1:0] live_bytes;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fbfl_ctrl.sv =====
// Controller of the free list allocator: capture and commit sequencing.
// Depends on fbfl_pkg.
`default_nettype none

module fbfl_ctrl
  import fbfl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_FINISH = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fbfl_dp.sv =====
// Datapath of the free list allocator: registers, link store, address math.
// Depends on fbfl_pkg; driven by fbfl_ctrl commands.
`default_nettype none

module fbfl_dp
  import fbfl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ctl_cmd_t              cmd,
  output dp_stat_t                   stat,
  input  wire req_t                  in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output rsp_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SIZE_W-1:0]     block_bytes;
  logic [ALIGN_W-1:0]    align_bytes;
  logic [ADDR_W-1:0]     pool_base;

  logic [LINK_W-1:0]     free_head, free_head_next;
  logic [COUNT_W-1:0]    alloc_count, alloc_count_next;
  logic [BYTES_W-1:0]    alloc_bytes, alloc_bytes_next;

  logic [LINK_W-1:0]     link_mem [BLOCK_COUNT];
  logic [BLOCK_COUNT-1:0] link_valid;
  logic [LINK_W-1:0]     link_q;
  logic                  link_q_valid;

  logic [2:0]            req_status;
  logic                  req_update;
  logic                  req_free;
  logic [IDX_W-1:0]      req_idx;
  logic [IDX_W-1:0]      head_q;
  logic [PROD_W-1:0]     prod;

  logic [2:0]            status_next;
  logic                  update_next;
  logic [STRIDE_W-1:0]   stride;
  logic [IDX_W-1:0]      head_idx;
  logic [LINK_W-1:0]     pop_link;
  logic [ADDR_W-1:0]     grant_addr;
  logic                  grant;
  rsp_t                  rsp_next;

  assign stat.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= BLOCK_BYTES_RST;
      align_bytes <= ALIGN_BYTES_RST;
      pool_base   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BLOCK_BYTES: block_bytes <= cfg_data[SIZE_W-1:0];
        CFG_ALIGN_BYTES: align_bytes <= cfg_data[ALIGN_W-1:0];
        CFG_POOL_BASE:   pool_base   <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign stride   = {1'b0, block_bytes} + {{(STRIDE_W-ALIGN_W){1'b0}}, align_bytes};
  assign head_idx = free_head[IDX_W-1:0];

  always_comb begin
    status_next = ST_OK;
    update_next = 1'b0;
    if (in_data.mode == MODE_ALLOC) begin
      priority if (in_data.request_size != block_bytes) begin
        status_next = ST_SIZE;
      end else if (in_data.request_align != align_bytes) begin
        status_next = ST_ALIGN;
      end else if (free_head >= NULL_LINK) begin
        status_next = ST_EMPTY;
      end else begin
        update_next = 1'b1;
      end
    end else begin
      priority if (in_data.is_null ||
                   ({1'b0, in_data.block_index} >= NULL_LINK)) begin
        status_next = ST_OK;
      end else if (alloc_count == '0) begin
        status_next = ST_NONE;
      end else begin
        update_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_status   <= status_next;
      req_update   <= update_next;
      req_free     <= (in_data.mode == MODE_FREE);
      req_idx      <= in_data.block_index;
      head_q       <= head_idx;
      prod         <= PROD_W'(head_idx) * PROD_W'(stride);
      link_q       <= link_mem[head_idx];
      link_q_valid <= link_valid[head_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && req_update && req_free) begin
      link_mem[req_idx] <= free_head;
    end
  end

  assign pop_link   = link_q_valid ? link_q : ({1'b0, head_q} + LINK_W'(1));
  assign grant_addr = pool_base + {{(ADDR_W-PROD_W){1'b0}}, prod};
  assign grant      = req_update && !req_free;

  always_comb begin
    free_head_next   = free_head;
    alloc_count_next = alloc_count;
    alloc_bytes_next = alloc_bytes;
    if (req_update) begin
      if (req_free) begin
        free_head_next   = {1'b0, req_idx};
        alloc_count_next = alloc_count - COUNT_W'(1);
        alloc_bytes_next = alloc_bytes - {{(BYTES_W-SIZE_W){1'b0}}, block_bytes};
      end else begin
        free_head_next   = pop_link;
        alloc_count_next = alloc_count + COUNT_W'(1);
        alloc_bytes_next = alloc_bytes + {{(BYTES_W-SIZE_W){1'b0}}, block_bytes};
      end
    end
    rsp_next.status          = req_status;
    rsp_next.granted_index   = grant ? head_q : '0;
    rsp_next.granted_address = grant ? grant_addr : '0;
    rsp_next.live_blocks     = alloc_count_next;
    rsp_next.live_bytes      = alloc_bytes_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head   <= '0;
      alloc_count <= '0;
      alloc_bytes <= '0;
      link_valid  <= '0;
    end else if (cmd.commit) begin
      free_head   <= free_head_next;
      alloc_count <= alloc_count_next;
      alloc_bytes <= alloc_bytes_next;
      if (req_update && req_free) begin
        link_valid[req_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fixed_block_free_list_allocator.sv =====
// Fixed block pool allocator with a linked free list, top level.
// A transfer in is captured, then committed to the output register once the
// output is not stalled; one item at a time, since the link store read is
// registered and the pop of the head needs it before the next item is taken.
// Reset: synchronous; head at block zero, counts zero, registers at defaults.
// Depends on fbfl_pkg, fbfl_ctrl and fbfl_dp.
`default_nettype none

module fixed_block_free_list_allocator
  import fbfl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire req_t                  in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output rsp_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  fbfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fbfl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/fbfl_checker.sv =====
// Port level checks of the free list allocator, bound to the top level.
// Depends on fbfl_pkg and fixed_block_free_list_allocator.
`default_nettype none

module fbfl_checker
  import fbfl_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire rsp_t                  out_data
);

  a_reset_clean: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("outputs not clear after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transfer taken while an item is in flight");

  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status != ST_OK)) |->
      ((out_data.granted_index == '0) && (out_data.granted_address == '0)))
    else $error("grant fields set on a failed request");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("stalled result changed");

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
